/* design/tifl_pkg.sv */
// Shared constants and control types for the timestamp index floor lookup.
`default_nettype none

package tifl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KIND_W      = 2;
  localparam int STAMP_W     = 64;
  localparam int OFFSET_W    = 64;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  // Read address source for the table memories.
  typedef enum logic [1:0] {
    RD_START,
    RD_STEP,
    RD_CHECK,
    RD_HOLD
  } rd_sel_t;

  // What the result register takes.
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_DROP,
    RES_ENTRY
  } res_src_t;

  typedef struct packed {
    logic     clear;
    logic     append_wr;
    logic     start;
    logic     step;
    logic     check;
    rd_sel_t  rd_sel;
    logic     res_load;
    res_src_t res_src;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic span_next_zero;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/tifl_stream_if.sv */
// Request and response channel interfaces.
`default_nettype none

interface tifl_req_if;
  logic                           valid;
  logic                           ready;
  logic [tifl_pkg::KIND_W-1:0]    kind;
  logic [tifl_pkg::STAMP_W-1:0]   timestamp;
  logic [tifl_pkg::OFFSET_W-1:0]  store_offset;

  modport source (output valid, output kind, output timestamp, output store_offset,
                  input ready);
  modport sink (input valid, input kind, input timestamp, input store_offset,
                output ready);
endinterface

interface tifl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [tifl_pkg::STAMP_W-1:0]   entry_timestamp;
  logic [tifl_pkg::OFFSET_W-1:0]  entry_offset;
  logic                           dropped;

  modport source (output valid, output found, output entry_timestamp,
                  output entry_offset, output dropped, input ready);
  modport sink (input valid, input found, input entry_timestamp,
                input entry_offset, input dropped, output ready);
endinterface

`default_nettype wire

/* design/tifl_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tifl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* design/tifl_datapath.sv */
// Table memories, entry count, search registers and result register.
`default_nettype none

module tifl_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tifl_pkg::dp_cmd_t               cmd,
  output tifl_pkg::dp_status_t                 status,
  input  wire logic [tifl_pkg::STAMP_W-1:0]    in_timestamp,
  input  wire logic [tifl_pkg::OFFSET_W-1:0]   in_offset,
  output logic                                 res_found,
  output logic      [tifl_pkg::STAMP_W-1:0]    res_timestamp,
  output logic      [tifl_pkg::OFFSET_W-1:0]   res_offset,
  output logic                                 res_dropped
);
  import tifl_pkg::*;

  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    lo;
  logic [CNT_W-1:0]    span;
  logic [STAMP_W-1:0]  key;

  logic [STAMP_W-1:0]  rd_stamp;
  logic [OFFSET_W-1:0] rd_offset;
  logic [ADDR_W-1:0]   rd_addr;

  logic [CNT_W-1:0]    half;
  logic [CNT_W-1:0]    mid;
  logic                probe_lt;
  logic [CNT_W-1:0]    lo_next;
  logic [CNT_W-1:0]    span_next;
  logic [CNT_W-1:0]    probe_addr;
  logic [CNT_W-1:0]    sel;

  // One probe per cycle: rd_stamp holds stamp[mid] of the current lo/span.
  always_comb begin
    half      = span >> 1;
    mid       = lo + half;
    probe_lt  = rd_stamp < key;
    lo_next   = probe_lt ? mid + CNT_W'(1) : lo;
    span_next = probe_lt ? span - half - CNT_W'(1) : half;
    // Next probe, or the lower-bound position once the span runs out
    probe_addr = (span_next != '0) ? lo_next + (span_next >> 1) : lo_next;
    // Floor pick: rd_stamp holds stamp[lo] here when lo is inside the table
    if (lo == '0) begin
      sel = '0;
    end else if (lo >= entry_count || rd_stamp != key) begin
      sel = lo - CNT_W'(1);
    end else begin
      sel = lo;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_START: rd_addr = ADDR_W'(entry_count >> 1);
      RD_STEP:  rd_addr = probe_addr[ADDR_W-1:0];
      RD_CHECK: rd_addr = sel[ADDR_W-1:0];
      RD_HOLD:  rd_addr = lo[ADDR_W-1:0];
      default:  rd_addr = lo[ADDR_W-1:0];
    endcase
  end

  assign status.count_zero     = (entry_count == '0);
  assign status.count_full     = (entry_count >= CNT_W'(TABLE_DEPTH));
  assign status.span_next_zero = (span_next == '0);

  tifl_ram #(.WIDTH(STAMP_W), .DEPTH(TABLE_DEPTH)) u_stamp_ram (
    .clk     (clk),
    .wr_en   (cmd.append_wr),
    .wr_addr (entry_count[ADDR_W-1:0]),
    .wr_data (in_timestamp),
    .rd_addr (rd_addr),
    .rd_data (rd_stamp)
  );

  tifl_ram #(.WIDTH(OFFSET_W), .DEPTH(TABLE_DEPTH)) u_offset_ram (
    .clk     (clk),
    .wr_en   (cmd.append_wr),
    .wr_addr (entry_count[ADDR_W-1:0]),
    .wr_data (in_offset),
    .rd_addr (rd_addr),
    .rd_data (rd_offset)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.clear) begin
      entry_count <= '0;
    end else if (cmd.append_wr) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key  <= in_timestamp;
      lo   <= '0;
      span <= entry_count;
    end else if (cmd.step) begin
      lo   <= lo_next;
      span <= span_next;
    end else if (cmd.check) begin
      lo   <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_src)
        RES_ENTRY: begin
          res_found     <= 1'b1;
          res_timestamp <= rd_stamp;
          res_offset    <= rd_offset;
          res_dropped   <= 1'b0;
        end
        RES_DROP: begin
          res_found     <= 1'b0;
          res_timestamp <= '0;
          res_offset    <= '0;
          res_dropped   <= 1'b1;
        end
        default: begin
          res_found     <= 1'b0;
          res_timestamp <= '0;
          res_offset    <= '0;
          res_dropped   <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/tifl_ctrl.sv */
// Control state machine: decodes items, sequences the search, owns the response valid.
`default_nettype none

module tifl_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  input  wire logic [tifl_pkg::KIND_W-1:0]   req_kind,
  output logic                               req_ready,
  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  input  wire tifl_pkg::dp_status_t          status,
  output tifl_pkg::dp_cmd_t                  cmd
);
  import tifl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_CHECK,
    S_FETCH
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   req_beat;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign req_beat  = req_valid && req_ready;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_HOLD;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_beat) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_ZERO;
          case (req_kind)
            KIND_CLEAR: cmd.clear = 1'b1;
            KIND_APPEND: begin
              if (status.count_full) begin
                cmd.res_src = RES_DROP;
              end else begin
                cmd.append_wr = 1'b1;
              end
            end
            KIND_LOOKUP: begin
              if (!status.count_zero) begin
                cmd.res_load = 1'b0;
                cmd.start    = 1'b1;
                cmd.rd_sel   = RD_START;
                state_next   = S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        cmd.step   = 1'b1;
        cmd.rd_sel = RD_STEP;
        if (status.span_next_zero) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        cmd.rd_sel = RD_CHECK;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        // read data stays put while the address holds
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_ENTRY;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= (rsp_valid && !rsp_ready) || cmd.res_load;
    end
  end

endmodule

`default_nettype wire

/* design/timestamp_index_floor_lookup.sv */
// Top level of the timestamp index with floor lookup.
// Holds up to TABLE_DEPTH (timestamp, offset) pairs and answers one item at a time with
// exactly one response beat. Clear, append, unused kinds and a lookup on an empty table
// are done on the request beat and their response is valid on the next cycle. A lookup is a
// lower-bound binary search that probes the stamp memory once per cycle: at most
// floor(log2(entry_count)) + 1 probes (11 for 1024 entries), then a check state tests the
// landing entry for an exact match and a fetch state reads the chosen entry into the
// response register. The single read port of the stamp memory limits the search to one
// probe at a time. A new request is taken once the block is idle and its response
// register is empty or being drained.
`default_nettype none

module timestamp_index_floor_lookup (
  input  wire logic clk,
  input  wire logic rst,
  tifl_req_if.sink  req,
  tifl_rsp_if.source rsp
);
  import tifl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tifl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tifl_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_timestamp   (req.timestamp),
    .in_offset      (req.store_offset),
    .res_found      (rsp.found),
    .res_timestamp  (rsp.entry_timestamp),
    .res_offset     (rsp.entry_offset),
    .res_dropped    (rsp.dropped)
  );

endmodule

`default_nettype wire

/* design/tifl_checker.sv */
// Port-level checker for the timestamp index, bound to the top level.
`default_nettype none

module tifl_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic                          found,
  input wire logic [tifl_pkg::STAMP_W-1:0]  entry_timestamp,
  input wire logic [tifl_pkg::OFFSET_W-1:0] entry_offset,
  input wire logic                          dropped
);

  logic       req_beat;
  logic       rsp_beat;
  logic [1:0] pending;

  assign req_beat = req_valid && req_ready;
  assign rsp_beat = rsp_valid && rsp_ready;

  // requests taken minus responses delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_beat && !rsp_beat) begin
      pending <= pending + 2'd1;
    end else if (!req_beat && rsp_beat) begin
      pending <= pending - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(dropped)
      && $stable(entry_timestamp) && $stable(entry_offset))
    else $error("response beat changed while stalled");

  a_found_xor_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(found && dropped))
    else $error("response both found and dropped");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> entry_timestamp == '0 && entry_offset == '0)
    else $error("entry fields nonzero without a found entry");

  a_one_pending: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending == 2'd1)
    else $error("response without exactly one outstanding request");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd0 && !rsp_beat |-> !req_beat)
    else $error("request taken while an earlier one is still outstanding");

endmodule

bind timestamp_index_floor_lookup tifl_checker u_tifl_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .found           (rsp.found),
  .entry_timestamp (rsp.entry_timestamp),
  .entry_offset    (rsp.entry_offset),
  .dropped         (rsp.dropped)
);

`default_nettype wire
